// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check on clk with asynchronous reset disable
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication check
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== src/bpcs_pkg.sv =====
`timescale 1ns / 1ps
package bpcs_pkg;
    localparam int NumBuffers = 64;
    localparam int UseMax = 5;
    localparam int IdW = $clog2(NumBuffers);
    localparam int SizeW = IdW + 1;
    localparam int UseW = $clog2(UseMax + 1);
    localparam int RefW = 16;
    localparam int LinkW = IdW + 1;
    localparam int StepW = $clog2((UseMax + 1) * NumBuffers + 1);
    localparam logic [SizeW-1:0] ListEnd = SizeW'(NumBuffers);
    localparam logic [RefW-1:0] RefLimit = '1;

    typedef enum logic [2:0] {
        KIND_PIN = 3'd0, KIND_UNPIN = 3'd1, KIND_SET_DIRTY = 3'd2,
        KIND_CLR_DIRTY = 3'd3, KIND_SET_VALID = 3'd4, KIND_INVALIDATE = 3'd5,
        KIND_POP = 3'd6, KIND_SWEEP = 3'd7
    } kind_t;

    // one descriptor entry
    typedef struct packed {
        logic            valid;
        logic            dirty;
        logic            listed;
        logic [RefW-1:0] refs;
        logic [UseW-1:0] uses;
        logic [LinkW-1:0] link;
    } desc_t;

    localparam int DescW = $bits(desc_t);

    typedef struct packed {
        logic [2:0]     kind;
        logic [IdW-1:0] buffer_id;
        logic           valid_flag;
    } req_t;

    typedef struct packed {
        logic            found;
        logic [IdW-1:0]  result_id;
        logic [RefW-1:0] ref_count_out;
        logic            valid_out;
        logic            dirty_out;
    } rsp_t;
endpackage

// ===== src/bpcs_if.sv =====
`timescale 1ns / 1ps
interface bpcs_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bpcs_ram.sv =====
`timescale 1ns / 1ps
module bpcs_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/bpcs_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bpcs_ctrl
    import bpcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [SizeW-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    output logic             ram_we,
    output logic [IdW-1:0]   ram_waddr,
    output desc_t            ram_wdata,
    output logic [IdW-1:0]   ram_raddr,
    input  desc_t            ram_rdata
);
    typedef enum logic [7:0] {
        ST_INIT  = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_RD    = 8'b00000100,
        ST_OP    = 8'b00001000,
        ST_HEAD  = 8'b00010000,
        ST_POP   = 8'b00100000,
        ST_SWEEP = 8'b01000000,
        ST_LINK  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic [SizeW-1:0] size_reg, size_next;
    logic [IdW-1:0] init_reg, init_next;
    logic [IdW-1:0] start_reg, start_next;
    logic [IdW-1:0] cur_reg, cur_next;
    logic [LinkW-1:0] head_reg, head_next;
    logic [StepW-1:0] step_reg, step_next;
    req_t req_reg, req_next;
    logic out_v_reg, out_v_next;
    rsp_t out_reg, out_next;
    logic [SizeW-1:0] wr_size;
    logic [IdW-1:0] cur_inc;
    logic [SizeW-1:0] cur_ext;
    desc_t d;
    logic [UseW-1:0] dec_use;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign req_ready = (state_reg == ST_IDLE) && !cfg_valid && !out_v_reg;
    assign rsp_valid = out_v_reg;
    assign rsp = out_reg;
    assign d = ram_rdata;
    assign cur_ext = {1'b0, cur_reg};
    assign cur_inc = (cur_ext + 1'b1 == size_reg) ? '0 : cur_reg + 1'b1;
    assign dec_use = (d.uses != '0) ? d.uses - 1'b1 : d.uses;

    // clamp written pool size
    always_comb
    begin
        wr_size = cfg_data;
        if (cfg_data < SizeW'(2))
        begin
            wr_size = SizeW'(2);
        end
        else if (cfg_data > ListEnd)
        begin
            wr_size = ListEnd;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        size_next = size_reg;
        init_next = init_reg;
        start_next = start_reg;
        cur_next = cur_reg;
        head_next = head_reg;
        step_next = step_reg;
        req_next = req_reg;
        out_v_next = out_v_reg;
        out_next = out_reg;
        ram_we = 1'b0;
        ram_waddr = cur_reg;
        ram_wdata = d;
        ram_raddr = cur_reg;
        if (out_v_reg && rsp_ready)
        begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            ST_INIT:
            begin
                // clearing pass, entry 0 doubles as list head
                ram_we = 1'b1;
                ram_waddr = init_reg;
                ram_wdata = '0;
                ram_wdata.listed = (init_reg != '0) && ({1'b0, init_reg} < size_reg);
                ram_wdata.link = ({1'b0, init_reg} + 1'b1 < size_reg) ?
                                 LinkW'({1'b0, init_reg} + 1'b1) : ListEnd;
                init_next = init_reg + 1'b1;
                if (init_reg == IdW'(NumBuffers - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    size_next = wr_size;
                    init_next = '0;
                    start_next = '0;
                    state_next = ST_INIT;
                end
                else if (req_ready && req_valid)
                begin
                    req_next = req;
                    if (req.kind == KIND_POP)
                    begin
                        ram_raddr = '0;
                        state_next = ST_HEAD;
                    end
                    else if (req.kind == KIND_SWEEP)
                    begin
                        cur_next = ({1'b0, start_reg} < size_reg) ? start_reg : '0;
                        ram_raddr = ({1'b0, start_reg} < size_reg) ? start_reg : '0;
                        step_next = '0;
                        state_next = ST_SWEEP;
                    end
                    else if ({1'b0, req.buffer_id} >= size_reg)
                    begin
                        out_v_next = 1'b1;
                        out_next = '0;
                        out_next.result_id = req.buffer_id;
                    end
                    else
                    begin
                        ram_raddr = req.buffer_id;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                // entry of the addressed buffer now on rdata; head needed for push
                cur_next = req_reg.buffer_id;
                ram_raddr = '0;
                ram_we = 1'b1;
                ram_waddr = req_reg.buffer_id;
                ram_wdata = d;
                case (kind_t'(req_reg.kind))
                    KIND_PIN:
                    begin
                        ram_wdata.uses = UseW'(UseMax);
                        if (d.refs != RefLimit)
                        begin
                            ram_wdata.refs = d.refs + 1'b1;
                        end
                    end
                    KIND_UNPIN:
                    begin
                        if (d.refs != '0)
                        begin
                            ram_wdata.refs = d.refs - 1'b1;
                        end
                    end
                    KIND_SET_DIRTY: ram_wdata.dirty = 1'b1;
                    KIND_CLR_DIRTY: ram_wdata.dirty = 1'b0;
                    KIND_SET_VALID: ram_wdata.valid = req_reg.valid_flag;
                    default:        ram_wdata.valid = 1'b0;
                endcase
                out_next.found = 1'b1;
                out_next.result_id = req_reg.buffer_id;
                out_next.valid_out = ram_wdata.valid;
                out_next.dirty_out = ram_wdata.dirty;
                out_next.ref_count_out = ram_wdata.refs;
                if ((req_reg.kind == KIND_INVALIDATE) && (req_reg.buffer_id != '0)
                    && !d.listed)
                begin
                    ram_wdata.listed = 1'b1;
                    state_next = ST_OP;
                end
                else
                begin
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OP:
            begin
                // push: rdata holds head entry; relink head to the buffer, then the buffer
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = d;
                ram_wdata.link = {1'b0, req_reg.buffer_id};
                head_next = d.link;
                state_next = ST_POP;
                step_next = '1;
            end
            ST_HEAD:
            begin
                // rdata holds entry 0
                if ((d.link >= LinkW'(size_reg)) || (d.link >= ListEnd))
                begin
                    out_v_next = 1'b1;
                    out_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    head_next = d.link;
                    cur_next = d.link[IdW-1:0];
                    ram_raddr = d.link[IdW-1:0];
                    step_next = '0;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (step_reg == '1)
                begin
                    // finish push: buffer takes old head link, listed set
                    ram_we = 1'b1;
                    ram_waddr = req_reg.buffer_id;
                    ram_wdata = '0;
                    ram_wdata.valid = 1'b0;
                    ram_wdata.dirty = out_reg.dirty_out;
                    ram_wdata.listed = 1'b1;
                    ram_wdata.refs = out_reg.ref_count_out;
                    ram_wdata.uses = d.uses;
                    ram_wdata.link = head_reg;
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // rdata holds popped entry: unlist it, head moves to its link
                    ram_we = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = d;
                    ram_wdata.listed = 1'b0;
                    head_next = d.link;
                    if (d.refs == '0)
                    begin
                        out_next.found = 1'b1;
                        out_next.result_id = cur_reg;
                        out_next.ref_count_out = d.refs;
                        out_next.valid_out = d.valid;
                        out_next.dirty_out = d.dirty;
                        ram_raddr = '0;
                        state_next = ST_LINK;
                    end
                    else if ((d.link >= LinkW'(size_reg)) || (d.link >= ListEnd))
                    begin
                        out_next = '0;
                        ram_raddr = '0;
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        cur_next = d.link[IdW-1:0];
                        ram_raddr = d.link[IdW-1:0];
                    end
                end
            end
            ST_LINK:
            begin
                // rdata holds entry 0: store the new list head
                ram_we = 1'b1;
                ram_waddr = '0;
                ram_wdata = d;
                ram_wdata.link = head_reg;
                out_v_next = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                ram_we = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = d;
                if (!d.valid || ((d.refs == '0) && (dec_use == '0)))
                begin
                    ram_wdata.uses = d.valid ? dec_use : d.uses;
                    out_v_next = 1'b1;
                    out_next.found = 1'b1;
                    out_next.result_id = cur_reg;
                    out_next.ref_count_out = d.refs;
                    out_next.valid_out = d.valid;
                    out_next.dirty_out = d.dirty;
                    start_next = cur_inc;
                    state_next = ST_IDLE;
                end
                else if (StepW'(step_reg + 1'b1) ==
                         StepW'(StepW'(UseMax + 1) * StepW'(size_reg)))
                begin
                    ram_wdata.uses = dec_use;
                    out_v_next = 1'b1;
                    out_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_wdata.uses = dec_use;
                    step_next = step_reg + 1'b1;
                    cur_next = cur_inc;
                    ram_raddr = cur_inc;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            size_reg <= ListEnd;
            init_reg <= '0;
            start_reg <= '0;
            out_v_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg <= size_next;
            init_reg <= init_next;
            start_reg <= start_next;
            out_v_reg <= out_v_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        head_reg <= head_next;
        req_reg <= req_next;
        out_reg <= out_next;
    end

    `ASSERT_IMPL(a_ready_idle, req_ready, state_reg == ST_IDLE, "ready outside idle")
    `ASSERT_IMPL(a_size_range, state_reg == ST_IDLE,
                 size_reg >= SizeW'(2) && size_reg <= ListEnd, "pool size out of range")
    `ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready, "second accept")
endmodule

// ===== src/buffer_pool_clock_sweep_core.sv =====
`timescale 1ns / 1ps
// simple ops read and write the descriptor; an invalidate that pushes onto the free
// list also relinks the list head and then the buffer
// pop: reads entry 0, then walks the list to an entry with no refs or to its end
// sweep: visits descriptors in turn, at most (UseMax+1)*pool_size of them
// one transaction in flight; the next request waits until the result is accepted
// reset and each pool_size write clear all 64 entries in a pass, no request taken
module buffer_pool_clock_sweep_core
    import bpcs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    bpcs_if.sink   cfg,
    bpcs_if.sink   req,
    bpcs_if.source rsp
);
    logic ram_we;
    logic [IdW-1:0] ram_waddr, ram_raddr;
    desc_t ram_wdata, ram_rdata;

    bpcs_ram #(.Width(DescW), .Depth(NumBuffers)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_ready (cfg.ready),
        .cfg_data  (cfg.data),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp       (rsp.data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );
endmodule
